### hw/rtl/quoted_argument_tokenizer_core_assert.svh
// Assertion macros shared by the tokenizer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define QAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/qat_pkg.sv
`timescale 1ns / 1ps
package qat_pkg;

  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam int MaxRes = 3;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END_ARG  = 2'd1,
    KIND_END_TEXT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg_byte;
  } res_t;

  // up to three results of one request, res[0] goes out first
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic between_args;
    logic in_double;
    logic in_single;
    logic escape_pending;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{between_args: 1'b1, in_double: 1'b0,
                                       in_single: 1'b0, escape_pending: 1'b0};

  typedef struct packed {
    logic       emit;
    res_t       res;
    tok_state_t st;
  } plain_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // handling of a byte with no escape in effect
  function automatic plain_t plain_fn(input logic [7:0] c, input tok_state_t st);
    plain_t p;
    p.emit = 1'b0;
    p.res  = '{kind: KIND_BYTE, arg_byte: c};
    p.st   = st;
    if (c == CH_DQ) begin
      if (st.in_single) p.emit = 1'b1;
      else p.st.in_double = !st.in_double;
    end else if (c == CH_SQ) begin
      if (st.in_double) p.emit = 1'b1;
      else p.st.in_single = !st.in_single;
    end else if ((c == CH_SP) || (c == CH_TAB)) begin
      p.emit = 1'b1;
      if (!(st.in_double || st.in_single)) begin
        p.res = '{kind: KIND_END_ARG, arg_byte: 8'h00};
        p.st.between_args = 1'b1;
      end
    end else if (c == CH_BS) begin
      if (st.in_single) p.emit = 1'b1;
      else p.st.escape_pending = 1'b1;
    end else begin
      p.emit = 1'b1;
    end
    plain_fn = p;
  endfunction

endpackage

### hw/rtl/qat_in_if.sv
`timescale 1ns / 1ps
interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### hw/rtl/qat_out_if.sv
`timescale 1ns / 1ps
interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] arg_byte;
  logic       last;

  modport source (output valid, output kind, output arg_byte, output last, input ready);
  modport sink   (input valid, input kind, input arg_byte, input last, output ready);
endinterface

### hw/rtl/quoted_argument_tokenizer_core.sv
`timescale 1ns / 1ps
// Shell-style quoted argument splitter.
// in_chan  : one text byte per request (text_byte, end_of_text); a zero byte or
//            end_of_text ends the text and returns the parser to idle.
// out_chan : one result per request: kind (byte / end of argument / end of
//            text), arg_byte, and last on the final result of an input request.
// An input request gives 0..3 results. Its state update is done at accept
// time; the results are queued as one bundle in a 2-deep bundle queue and
// leave one per cycle while the receiver is ready, behind any older bundle.
// Throughput: one input per cycle while the receiver is ready and each input
// yields at most one result; an input with more results holds the output
// until all are out, so the output port (one result per cycle) sets the rate.
// in_chan.ready comes from the queue fill count alone, so no combinational
// path runs from out_chan.ready to in_chan.ready. Inputs with no result
// (skipped whitespace, quote toggles) never enter the queue.
// Reset (synchronous, rst_n low) clears the queue and puts the parser in the
// between-arguments state. When the receiver stalls, the head result holds,
// and inputs keep coming until both queue slots are taken.
module quoted_argument_tokenizer_core (
  input  logic       clk,
  input  logic       rst_n,
  qat_in_if.sink     in_chan,
  qat_out_if.source  out_chan
);

  logic             fire;
  logic             push;
  logic             can_push;
  qat_pkg::bundle_t bundle;
  qat_pkg::res_t    res;

  assign in_chan.ready = can_push;
  assign fire          = in_chan.valid && can_push;

  // flag state and per-request result decode
  qat_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .text_byte   (in_chan.text_byte),
    .end_of_text (in_chan.end_of_text),
    .push        (push),
    .bundle      (bundle)
  );

  // bundle queue, serialized one result per cycle while the receiver is ready
  qat_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (bundle),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res),
    .out_last  (out_chan.last)
  );

  assign out_chan.kind     = res.kind;
  assign out_chan.arg_byte = res.arg_byte;

endmodule

### hw/rtl/qat_parser.sv
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_core_assert.svh"
module qat_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               push,
  output qat_pkg::bundle_t   bundle
);

  qat_pkg::tok_state_t state_r, state_nxt;

  always_comb begin
    qat_pkg::tok_state_t st;
    qat_pkg::plain_t     p;
    qat_pkg::bundle_t    b;
    logic                run_plain;

    st        = state_r;
    b         = '0;
    run_plain = 1'b0;

    if (end_of_text || (text_byte == qat_pkg::CH_NUL)) begin
      if (!st.between_args) begin
        if (st.escape_pending && st.in_double) begin
          b.res[b.cnt] = '{kind: qat_pkg::KIND_BYTE, arg_byte: qat_pkg::CH_BS};
          b.cnt        = b.cnt + 2'd1;
        end
        b.res[b.cnt] = '{kind: qat_pkg::KIND_END_ARG, arg_byte: 8'h00};
        b.cnt        = b.cnt + 2'd1;
      end
      b.res[b.cnt] = '{kind: qat_pkg::KIND_END_TEXT, arg_byte: 8'h00};
      b.cnt        = b.cnt + 2'd1;
      st           = qat_pkg::TOK_RESET;
    end else if (st.between_args) begin
      if (!qat_pkg::is_space(text_byte)) begin
        st.between_args = 1'b0;
        run_plain       = 1'b1;
      end
    end else if (st.escape_pending) begin
      st.escape_pending = 1'b0;
      if (st.in_double) begin
        b.res[b.cnt] = '{kind: qat_pkg::KIND_BYTE, arg_byte:
                         ((text_byte == qat_pkg::CH_BS) || (text_byte == qat_pkg::CH_DQ))
                         ? text_byte : qat_pkg::CH_BS};
        b.cnt        = b.cnt + 2'd1;
        // backslash kept, the byte itself is then parsed as usual
        run_plain    = !((text_byte == qat_pkg::CH_BS) || (text_byte == qat_pkg::CH_DQ));
      end else begin
        b.res[b.cnt] = '{kind: qat_pkg::KIND_BYTE, arg_byte: text_byte};
        b.cnt        = b.cnt + 2'd1;
      end
    end else begin
      run_plain = 1'b1;
    end

    p = qat_pkg::plain_fn(text_byte, st);
    if (run_plain) begin
      st = p.st;
      if (p.emit) begin
        b.res[b.cnt] = p.res;
        b.cnt        = b.cnt + 2'd1;
      end
    end

    state_nxt = st;
    bundle    = b;
  end

  assign push = fire && (bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qat_pkg::TOK_RESET;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  `QAT_ASSERT_NEXT(a_end_resets, clk, rst_n, fire && end_of_text, state_r == qat_pkg::TOK_RESET, "terminator did not restore idle state")
  `QAT_ASSERT_NOW(a_esc_in_arg, clk, rst_n, state_r.escape_pending, !state_r.between_args && !state_r.in_single, "escape pending outside an argument or in single quotes")

endmodule

### hw/rtl/qat_res_fifo.sv
`timescale 1ns / 1ps
`include "quoted_argument_tokenizer_core_assert.svh"
module qat_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  qat_pkg::bundle_t  push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output qat_pkg::res_t     out_res,
  output logic              out_last
);

  qat_pkg::bundle_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;
  logic       pop;
  qat_pkg::bundle_t head;

  assign head      = mem_r[rd_ptr_r];
  assign out_valid = (count_r != 2'd0);
  assign out_res   = head.res[idx_r];
  assign out_last  = (idx_r == (head.cnt - 2'd1));
  assign can_push  = (count_r != 2'd2);
  assign take      = out_valid && out_ready;
  assign pop       = take && out_last;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    idx_nxt    = idx_r;
    if (take) idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  `QAT_ASSERT_NOW(a_idx_in_range, clk, rst_n, out_valid, idx_r < head.cnt, "result index beyond bundle")
  `QAT_ASSERT_NEXT(a_partial_stays, clk, rst_n, take && !out_last, out_valid && (idx_r == $past(idx_r) + 2'd1), "bundle dropped mid-way")

endmodule

### tb/sv/quoted_argument_tokenizer_core_tb.sv
`timescale 1ns / 1ps
module quoted_argument_tokenizer_core_tb;

  // cycles in a row with no request moving on either channel before we give up
  localparam int IDLE_LIMIT = 400;
  // random requests that actually reach the parser (skipped blanks not counted)
  localparam int RANDOM_REQS = 70;

  // one expected result of the splitter
  typedef struct {
    qat_pkg::kind_t kind;
    logic [7:0]     arg_byte;
    logic           last;
  } token_t;

  // Shadow parser plus the queue of tokens still owed by the block.
  class arg_split_scoreboard;
    bit skipping;     // between arguments, blanks are dropped
    bit in_dq;
    bit in_sq;
    bit esc;          // backslash waiting for its next byte
    token_t expected_tokens[$];
    qat_pkg::kind_t step_kind[$];
    logic [7:0] step_byte[$];
    int mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      skipping = 1'b1;
      in_dq    = 1'b0;
      in_sq    = 1'b0;
      esc      = 1'b0;
    endfunction

    function void emit(qat_pkg::kind_t k, logic [7:0] b);
      step_kind.push_back(k);
      step_byte.push_back(b);
    endfunction

    // byte with no escape in effect
    function void take_plain(logic [7:0] c);
      case (c)
        qat_pkg::CH_DQ: begin
          if (in_sq) emit(qat_pkg::KIND_BYTE, c);
          else in_dq = !in_dq;
        end
        qat_pkg::CH_SQ: begin
          if (in_dq) emit(qat_pkg::KIND_BYTE, c);
          else in_sq = !in_sq;
        end
        qat_pkg::CH_SP, qat_pkg::CH_TAB: begin
          if (in_dq || in_sq) begin
            emit(qat_pkg::KIND_BYTE, c);
          end else begin
            emit(qat_pkg::KIND_END_ARG, 8'h00);
            skipping = 1'b1;
          end
        end
        qat_pkg::CH_BS: begin
          if (in_sq) emit(qat_pkg::KIND_BYTE, c);
          else esc = 1'b1;
        end
        default: begin
          emit(qat_pkg::KIND_BYTE, c);
        end
      endcase
    endfunction

    // Accepted input request: queue its tokens. Returns 0 when the byte was a
    // skipped blank, i.e. the parser did nothing with it.
    function bit note_request(logic [7:0] b, logic eot);
      bit useful;
      int n;
      useful = 1'b1;
      step_kind.delete();
      step_byte.delete();
      if (eot || b == qat_pkg::CH_NUL) begin
        if (!skipping) begin
          // dangling backslash survives only inside double quotes
          if (esc && in_dq) emit(qat_pkg::KIND_BYTE, qat_pkg::CH_BS);
          emit(qat_pkg::KIND_END_ARG, 8'h00);
        end
        emit(qat_pkg::KIND_END_TEXT, 8'h00);
        restart();
      end else if (skipping) begin
        if (b == qat_pkg::CH_SP || (b >= qat_pkg::CH_TAB && b <= qat_pkg::CH_CR)) begin
          useful = 1'b0;
        end else begin
          skipping = 1'b0;
          take_plain(b);
        end
      end else if (esc) begin
        esc = 1'b0;
        if (!in_dq) begin
          emit(qat_pkg::KIND_BYTE, b);
        end else if (b == qat_pkg::CH_BS || b == qat_pkg::CH_DQ) begin
          emit(qat_pkg::KIND_BYTE, b);
        end else begin
          emit(qat_pkg::KIND_BYTE, qat_pkg::CH_BS);
          take_plain(b);
        end
      end else begin
        take_plain(b);
      end
      n = step_kind.size();
      for (int i = 0; i < n; i++)
        expected_tokens.push_back('{kind: step_kind[i], arg_byte: step_byte[i],
                                    last: (i == n - 1)});
      return useful;
    endfunction

    function void check_token(logic [1:0] k, logic [7:0] b, logic l);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: kind %0d arg_byte %02h last %0b", k, b, l);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (k !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, k);
          mismatches++;
        end
        if (b !== want.arg_byte) begin
          $error("arg_byte: expected %02h, got %02h", want.arg_byte, b);
          mismatches++;
        end
        if (l !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, l);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;          // while set, neither side inserts gaps
  int   useful_reqs;
  int   idle_cycles;

  qat_in_if  in_ch();
  qat_out_if out_ch();

  arg_split_scoreboard splitter = new();

  quoted_argument_tokenizer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Text byte biased toward the characters that steer the parser.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return qat_pkg::CH_DQ;
    if (r < 20) return qat_pkg::CH_SQ;
    if (r < 30) return qat_pkg::CH_BS;
    if (r < 42) return qat_pkg::CH_SP;
    if (r < 47) return qat_pkg::CH_TAB;
    if (r < 52) return 8'($urandom_range(9, 13));       // TAB, LF, VT, FF or CR
    if (r < 80) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(1, 255));
  endfunction

  // Entered and left just after a falling edge. The request is held until the
  // block takes it; the scoreboard learns of it at the accepting edge.
  task automatic send_req(input logic [7:0] b, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    if (splitter.note_request(b, eot)) useful_reqs++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
  endtask

  // hold the sender off until every owed token has come out
  task automatic drain_tokens();
    in_ch.valid <= 1'b0;
    while (splitter.pending() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls of the same shape as the sender's gaps.
  initial begin : sink_side
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Flip between calm stretches (back-to-back traffic) and gappy ones.
  initial begin : pace
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(30, 120)) @(posedge clk);
      calm = ($urandom_range(0, 2) == 0);
    end
  end

  // Every result taken by the receiver is checked against the oldest token owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      splitter.check_token(out_ch.kind, out_ch.arg_byte, out_ch.last);
  end

  // Watchdog: nothing moving on either channel for too long means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  len;
    bit  drained_mid;
    idle_cycles       = 0;
    useful_reqs       = 0;
    drained_mid       = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed texts ---
    // leading blank skipped, empty quotes give an empty argument,
    // end_of_text with the byte ignored (all ones)
    send_str(" \"\"");
    send_req(8'hFF, 1'b1);
    // trailing backslash outside quotes is dropped at a zero-byte terminator
    send_str("a\\");
    send_req(qat_pkg::CH_NUL, 1'b0);
    // in double quotes: backslash before plain byte is kept, then a dangling
    // backslash comes out ahead of the end-of-argument mark
    send_str("\"\\x\\");
    send_req(qat_pkg::CH_NUL, 1'b1);
    // single quotes keep backslash and double quote literal; LF and 0xFF are
    // plain argument bytes once an argument is open; space ends it
    send_str("'\\\"'\n");
    send_req(8'hFF, 1'b0);
    send_str(" ");
    // escaped quote and backslash in double quotes, single quote literal
    // there, escaped space outside quotes, then the terminator
    send_str("\"\\\"\\\\'\"\\ ");
    send_req(8'h5A, 1'b1);
    drain_tokens();

    // --- random texts ---
    useful_reqs = 0;
    while (useful_reqs < RANDOM_REQS) begin
      if (!drained_mid && useful_reqs >= RANDOM_REQS / 2) begin
        drain_tokens();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        // noise: any byte, stray terminators, texts cut short
        len = $urandom_range(1, 6);
        repeat (len) send_req(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        len = $urandom_range(0, 10);
        repeat (len) send_req(pick_char(), 1'b0);
        if ($urandom_range(0, 1) == 0) send_req(qat_pkg::CH_NUL, 1'b0);
        else send_req(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    // let the block empty out; the watchdog catches a hang
    while (splitter.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (splitter.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/qat_pkg.sv
hw/rtl/qat_in_if.sv
hw/rtl/qat_out_if.sv
hw/rtl/qat_parser.sv
hw/rtl/qat_res_fifo.sv
hw/rtl/quoted_argument_tokenizer_core.sv
tb/sv/quoted_argument_tokenizer_core_tb.sv
